[rtl/bounded_array_table_engine_core_defines.svh]
// Assertion macros used by the table engine datapath.
`ifndef BOUNDED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH
`define BATE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BATE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/bate_pkg.sv]
// Shared types, codes and constants of the table engine.
package bate_pkg;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_DELETE = 3'd1, OP_TRANS = 3'd2,
    OP_MTF = 3'd3, OP_BSEARCH = 3'd4, OP_SORTED = 3'd5,
    OP_RSVD6 = 3'd6, OP_RSVD7 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_RANGE = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_LS_RD, S_LS_CMP, S_SW_RD,
    S_SW_WR, S_BS_RD, S_BS_CMP, S_SI_RD, S_SI_CMP, S_PUT, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PC_HOLD, PC_LOAD, PC_INC, PC_DEC
  } ptr_op_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    rd_ptr;
    logic    rd_ptrm1;
    logic    rd_ptrp1;
    logic    rd_lo;
    logic    wr_ptr_from_data;
    logic    wr_ptr_value;
    logic    wr_swap;
    logic    save_removed;
    logic    bs_step;
    logic    bs_init;
    logic    set_hit;
    logic    count_inc;
    logic    count_dec;
    logic    set_fail;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ptr_gt_idx;
    logic ptr_zero;
    logic ptr_lt_last;
    logic ptr_lt_n;
    logic rd_eq;
    logic rd_gt;
    logic bs_live;
    logic bs_eq;
    logic full;
    logic idx_gt_n;
    logic idx_ge_n;
  } sts_t;
endpackage

[rtl/bate_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bate_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/bate_ctrl.sv]
// Command sequencer of the table engine.
module bate_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_taken,
  input  bate_pkg::sts_t  sts,
  output bate_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  bate_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bate_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != bate_pkg::S_IDLE);
  assign done = (state_r == bate_pkg::S_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.ptr_op = bate_pkg::PC_HOLD;
    unique case (state_r)
      bate_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
          unique case (sts.op) inside
            bate_pkg::OP_INSERT: begin
              if (sts.idx_gt_n || sts.full) cmd.set_fail = 1'b1;
              else state_nxt = bate_pkg::S_UP_RD;
            end
            bate_pkg::OP_DELETE: begin
              if (sts.idx_ge_n) cmd.set_fail = 1'b1;
              else state_nxt = bate_pkg::S_DN_RD;
            end
            bate_pkg::OP_TRANS, bate_pkg::OP_MTF: state_nxt = bate_pkg::S_LS_RD;
            bate_pkg::OP_BSEARCH: begin
              cmd.bs_init = 1'b1;
              state_nxt = bate_pkg::S_BS_RD;
            end
            bate_pkg::OP_SORTED: begin
              if (sts.full) cmd.set_fail = 1'b1;
              else state_nxt = bate_pkg::S_SI_RD;
            end
            default: cmd.out_load = 1'b1;
          endcase
          if (state_nxt == bate_pkg::S_DONE) cmd.out_load = 1'b1;
        end
      end
      bate_pkg::S_UP_RD: begin
        if (sts.ptr_gt_idx) begin
          cmd.rd_ptrm1 = 1'b1;
          state_nxt = bate_pkg::S_UP_WR;
        end else begin
          state_nxt = bate_pkg::S_PUT;
        end
      end
      bate_pkg::S_UP_WR: begin
        cmd.wr_ptr_from_data = 1'b1;
        cmd.ptr_op = bate_pkg::PC_DEC;
        state_nxt = bate_pkg::S_UP_RD;
      end
      bate_pkg::S_DN_RD: begin
        cmd.rd_ptr = 1'b1;
        state_nxt = bate_pkg::S_DN_WR;
      end
      bate_pkg::S_DN_WR: begin
        cmd.save_removed = 1'b1;
        if (sts.ptr_lt_last) begin
          cmd.rd_ptrp1 = 1'b1;
          state_nxt = bate_pkg::S_PUT;
        end else begin
          cmd.count_dec = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
        end
      end
      bate_pkg::S_LS_RD: begin
        if (sts.ptr_lt_n) begin
          cmd.rd_ptr = 1'b1;
          state_nxt = bate_pkg::S_LS_CMP;
        end else begin
          cmd.set_fail = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
        end
      end
      bate_pkg::S_LS_CMP: begin
        if (sts.rd_eq) begin
          cmd.set_hit = 1'b1;
          if (sts.ptr_zero) begin
            cmd.out_load = 1'b1;
            state_nxt = bate_pkg::S_DONE;
          end else begin
            cmd.rd_lo = 1'b1;
            state_nxt = bate_pkg::S_SW_RD;
          end
        end else begin
          cmd.ptr_op = bate_pkg::PC_INC;
          state_nxt = bate_pkg::S_LS_RD;
        end
      end
      bate_pkg::S_SW_RD: begin
        cmd.wr_swap = 1'b1;
        state_nxt = bate_pkg::S_SW_WR;
      end
      bate_pkg::S_SW_WR: begin
        cmd.wr_ptr_value = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = bate_pkg::S_DONE;
      end
      bate_pkg::S_BS_RD: begin
        if (sts.bs_live) begin
          state_nxt = bate_pkg::S_BS_CMP;
          cmd.rd_ptr = 1'b1;
        end else begin
          cmd.set_fail = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
        end
      end
      bate_pkg::S_BS_CMP: begin
        if (sts.bs_eq) begin
          cmd.set_hit = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
        end else begin
          cmd.bs_step = 1'b1;
          state_nxt = bate_pkg::S_BS_RD;
        end
      end
      bate_pkg::S_SI_RD: begin
        if (!sts.ptr_zero) begin
          cmd.rd_ptrm1 = 1'b1;
          state_nxt = bate_pkg::S_SI_CMP;
        end else begin
          state_nxt = bate_pkg::S_PUT;
        end
      end
      bate_pkg::S_SI_CMP: begin
        if (sts.rd_gt) begin
          cmd.wr_ptr_from_data = 1'b1;
          cmd.ptr_op = bate_pkg::PC_DEC;
          state_nxt = bate_pkg::S_SI_RD;
        end else begin
          state_nxt = bate_pkg::S_PUT;
        end
      end
      bate_pkg::S_PUT: begin
        if (sts.op == bate_pkg::OP_DELETE) begin
          cmd.wr_ptr_from_data = 1'b1;
          cmd.ptr_op = bate_pkg::PC_INC;
          state_nxt = bate_pkg::S_DN_WR;
        end else begin
          cmd.wr_ptr_value = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.set_hit = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = bate_pkg::S_DONE;
        end
      end
      bate_pkg::S_DONE: begin
        if (out_taken) state_nxt = bate_pkg::S_IDLE;
      end
      default: state_nxt = bate_pkg::S_IDLE;
    endcase
  end
endmodule

[rtl/bate_dp.sv]
// Datapath of the table engine: element RAM, pointers, count and result registers.
`include "bounded_array_table_engine_core_defines.svh"
module bate_dp #(
  parameter int unsigned CAPACITY = bate_pkg::CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bate_pkg::cmd_t          cmd,
  output bate_pkg::sts_t          sts,
  input  logic [2:0]              in_op,
  input  logic [4:0]              in_idx,
  input  logic [31:0]             in_val,
  input  logic [4:0]              limit,
  output logic [1:0]              res_status,
  output logic [3:0]              res_position,
  output logic [31:0]             res_removed,
  output logic [4:0]              res_count
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 1;

  logic [2:0]    op_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   val_r, removed_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic signed [PW-1:0] lo_r, hi_r;
  logic          fail_r, hit_r;
  logic [CW-1:0] hitpos_r;

  logic [1:0]  status_r;
  logic [3:0]  position_r;
  logic [31:0] removed_out_r;
  logic [4:0]  count_out_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [CW-1:0] rd_sel;
  logic [CW-1:0] eff_lim;
  logic [CW-1:0] in_idx_c;
  logic          in_idx_big;
  logic signed [PW-1:0] mid;
  logic signed [PW:0]   lohi;

  bate_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    if (limit >= 5'(CAPACITY > 31 ? 31 : CAPACITY) && CAPACITY <= 31)
      eff_lim = CW'(CAPACITY);
    else
      eff_lim = CW'(limit);
    in_idx_big = (32'(in_idx) > 32'(CAPACITY));
    in_idx_c = in_idx_big ? CW'(CAPACITY) : CW'(in_idx);
  end

  assign lohi = {lo_r[PW-1], lo_r} + {hi_r[PW-1], hi_r};
  assign mid = PW'(lohi >>> 1);

  always_comb begin
    rd_sel = ptr_r;
    if (cmd.rd_ptrm1) rd_sel = ptr_r - 1'b1;
    else if (cmd.rd_ptrp1) rd_sel = ptr_r + 1'b1;
    else if (cmd.rd_lo) rd_sel = (op_r == bate_pkg::OP_MTF) ? '0 : ptr_r - 1'b1;
    else if (cmd.bs_init || op_r == bate_pkg::OP_BSEARCH) rd_sel = CW'(mid);
    raddr = rd_sel[AW-1:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata;
    if (cmd.wr_ptr_from_data) begin
      we = 1'b1;
    end else if (cmd.wr_swap) begin
      we = 1'b1;
      wdata = rdata;
    end else if (cmd.wr_ptr_value) begin
      we = 1'b1;
      wdata = val_r;
      if (op_r == bate_pkg::OP_TRANS) waddr = AW'(ptr_r - 1'b1);
      else if (op_r == bate_pkg::OP_MTF) waddr = '0;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    unique case (cmd.ptr_op)
      bate_pkg::PC_LOAD: ptr_nxt = '0;
      bate_pkg::PC_INC:  ptr_nxt = ptr_r + 1'b1;
      bate_pkg::PC_DEC:  ptr_nxt = ptr_r - 1'b1;
      default:           ptr_nxt = ptr_r;
    endcase
    if (cmd.load) begin
      unique case (bate_pkg::op_t'(in_op)) inside
        bate_pkg::OP_INSERT, bate_pkg::OP_SORTED: ptr_nxt = count_r;
        bate_pkg::OP_DELETE: ptr_nxt = in_idx_c;
        default: ptr_nxt = '0;
      endcase
    end
    if (cmd.bs_init || (cmd.rd_ptr && op_r == bate_pkg::OP_BSEARCH)) begin
      ptr_nxt = cmd.bs_init ? '0 : CW'(mid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_inc) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.count_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      op_r <= in_op;
      idx_r <= in_idx_c;
      val_r <= in_val;
      removed_r <= '0;
      fail_r <= cmd.set_fail;
      hit_r <= 1'b0;
      hitpos_r <= '0;
    end
    if (cmd.set_fail && !cmd.load) fail_r <= 1'b1;
    if (cmd.save_removed && ptr_r == idx_r) removed_r <= rdata;
    if (cmd.bs_init) begin
      lo_r <= '0;
      hi_r <= PW'(count_r) - 1'b1;
    end
    if (cmd.bs_step) begin
      if ($signed(val_r) < $signed(rdata)) hi_r <= PW'(ptr_r) - 1'b1;
      else lo_r <= PW'(ptr_r) + 1'b1;
    end
    if (cmd.set_hit) begin
      hit_r <= 1'b1;
      if (op_r == bate_pkg::OP_TRANS) hitpos_r <= (ptr_r == '0) ? '0 : ptr_r - 1'b1;
      else if (op_r == bate_pkg::OP_MTF) hitpos_r <= '0;
      else hitpos_r <= ptr_r;
    end
  end

  logic [1:0] fail_code;
  always_comb begin
    case (bate_pkg::op_t'(op_r))
      bate_pkg::OP_INSERT: fail_code = (idx_r > count_r) ? bate_pkg::ST_RANGE : bate_pkg::ST_FULL;
      bate_pkg::OP_DELETE: fail_code = bate_pkg::ST_RANGE;
      bate_pkg::OP_SORTED: fail_code = bate_pkg::ST_FULL;
      default:             fail_code = bate_pkg::ST_NOT_FOUND;
    endcase
  end

  logic [1:0]    st_now;
  logic [CW-1:0] pos_now;
  logic          op_ok;
  always_comb begin
    op_ok = cmd.load ? 1'b0 : 1'b1;
    st_now = (fail_r || cmd.set_fail) ? fail_code : bate_pkg::ST_OK;
    pos_now = hitpos_r;
    if (cmd.set_hit) begin
      if (op_r == bate_pkg::OP_TRANS) pos_now = (ptr_r == '0) ? '0 : ptr_r - 1'b1;
      else if (op_r == bate_pkg::OP_MTF) pos_now = '0;
      else pos_now = ptr_r;
    end else if (!(hit_r)) pos_now = '0;
    if (cmd.load) begin
      st_now = bate_pkg::ST_OK;
      pos_now = '0;
      if (cmd.set_fail) begin
        unique case (bate_pkg::op_t'(in_op))
          bate_pkg::OP_INSERT: st_now = (in_idx_big || in_idx_c > count_r) ?
                                        bate_pkg::ST_RANGE : bate_pkg::ST_FULL;
          bate_pkg::OP_DELETE: st_now = bate_pkg::ST_RANGE;
          default:             st_now = bate_pkg::ST_FULL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= st_now;
      position_r <= 4'(pos_now);
      removed_out_r <= (op_ok && op_r == bate_pkg::OP_DELETE) ?
                       (cmd.save_removed && ptr_r == idx_r ? rdata : removed_r) : '0;
      count_out_r <= 5'(cmd.count_inc ? count_r + 1'b1 :
                        cmd.count_dec ? count_r - 1'b1 : count_r);
    end
  end

  assign res_status = status_r;
  assign res_position = position_r;
  assign res_removed = removed_out_r;
  assign res_count = count_out_r;

  always_comb begin
    sts.op = bate_pkg::op_t'(cmd.load ? in_op : op_r);
    sts.ptr_gt_idx = ptr_r > idx_r;
    sts.ptr_zero = (ptr_r == '0);
    sts.ptr_lt_last = (32'(ptr_r) + 1) < 32'(count_r);
    sts.ptr_lt_n = ptr_r < count_r;
    sts.rd_eq = (rdata == val_r);
    sts.rd_gt = $signed(rdata) > $signed(val_r);
    sts.bs_live = (lo_r <= hi_r);
    sts.bs_eq = (rdata == val_r);
    sts.full = count_r >= eff_lim;
    sts.idx_gt_n = in_idx_big || (in_idx_c > count_r);
    sts.idx_ge_n = in_idx_big || (in_idx_c >= count_r);
  end

  `BATE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `BATE_ASSERT_IMPL(a_no_inc_dec, clk, rst_n, 1'b1, !(cmd.count_inc && cmd.count_dec))
  `BATE_ASSERT_NEXT(a_inc_grows, clk, rst_n, cmd.count_inc, count_r == $past(count_r) + 1'b1)
endmodule

[rtl/bounded_array_table_engine_core.sv]
// Top level of the bounded array table engine.
// Inserts and deletes shift the table one element at a time through the single element
// RAM port pair, linear searches read and compare one element at a time, and binary
// search reads and compares one probe at a time. One transaction is processed at a
// time; the result register holds the answer until it is taken, and the next item is
// accepted once it has been.
module bounded_array_table_engine_core #(
  parameter int unsigned CAPACITY = bate_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // opcode[2:0], index[7:3], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], position[5:2], removed_value[37:6],
                                  // count_now[42:38], zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [4:0] limit_r;
  bate_pkg::cmd_t cmd;
  bate_pkg::sts_t sts;
  logic busy, done, start;
  logic [1:0] st;
  logic [3:0] pos;
  logic [31:0] rem;
  logic [4:0] cnt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {27'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 5'd16;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      limit_r <= cfg_pwdata[4:0];
  end

  assign in_tready = !busy;
  assign start = in_tvalid && in_tready;
  assign out_tvalid = done;

  bate_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_taken(out_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  bate_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_tdata[2:0]), .in_idx(in_tdata[7:3]), .in_val(in_tdata[39:8]),
    .limit(limit_r), .res_status(st), .res_position(pos),
    .res_removed(rem), .res_count(cnt)
  );

  assign out_tdata = {5'd0, cnt, rem, pos, st};
endmodule

[tb/bounded_array_table_engine_core_test.sv]
// Self-checking testbench for the bounded array table engine: directed, fill, stall, random tests.
module bounded_array_table_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bate_pkg::op_t     op;
    logic [4:0]        idx;
    logic [31:0]       val;
    logic              known;
    bate_pkg::status_t st;
    logic [3:0]        pos;
    logic [31:0]       rem;
    logic [4:0]        cnt;
  } cmd_row_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [3:0]  pos;
    logic [31:0] rem;
    logic [4:0]  cnt;
  } answer_t;

  localparam int LIMIT = 20000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [39:0] in_tdata;
  logic [47:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  bounded_array_table_engine_core uut (.*);

  logic [31:0] tbl [0:15];
  logic [4:0] held;
  logic [4:0] cap_limit;
  answer_t answers_due [$];
  answer_t typed_due [$];
  logic typed_valid [$];
  int mismatches, watch;
  bit hold_off, no_idle;
  bit failed;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic answer_t predict_table(bate_pkg::op_t op, logic [4:0] idx,
                                            logic [31:0] val);
    answer_t a;
    logic [31:0] t;
    logic [4:0] lim;
    int i, lo, hi, mid;
    a = '0;
    lim = (cap_limit < 16) ? cap_limit : 5'd16;
    case (op) inside
      bate_pkg::OP_INSERT: begin
        if (idx > held) a.st = bate_pkg::ST_RANGE;
        else if (held >= lim) a.st = bate_pkg::ST_FULL;
        else begin
          for (i = held; i > idx; i--) tbl[i] = tbl[i-1];
          tbl[idx] = val;
          held++;
          a.pos = idx[3:0];
        end
      end
      bate_pkg::OP_DELETE: begin
        if (idx >= held) a.st = bate_pkg::ST_RANGE;
        else begin
          a.rem = tbl[idx];
          for (i = idx; i + 1 < held; i++) tbl[i] = tbl[i+1];
          held--;
        end
      end
      bate_pkg::OP_TRANS, bate_pkg::OP_MTF: begin
        a.st = bate_pkg::ST_NOT_FOUND;
        for (i = 0; i < held; i++) begin
          if (tbl[i] == val) begin
            a.st = bate_pkg::ST_OK;
            if (op == bate_pkg::OP_TRANS) begin
              if (i > 0) begin
                t = tbl[i]; tbl[i] = tbl[i-1]; tbl[i-1] = t;
                a.pos = 4'(i - 1);
              end
            end else begin
              t = tbl[i]; tbl[i] = tbl[0]; tbl[0] = t;
            end
            break;
          end
        end
      end
      bate_pkg::OP_BSEARCH: begin
        a.st = bate_pkg::ST_NOT_FOUND;
        lo = 0; hi = held - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if ($signed(val) == $signed(tbl[mid])) begin
            a.st = bate_pkg::ST_OK; a.pos = 4'(mid); break;
          end else if ($signed(val) < $signed(tbl[mid])) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      bate_pkg::OP_SORTED: begin
        if (held >= lim) a.st = bate_pkg::ST_FULL;
        else begin
          i = held;
          while (i > 0 && $signed(tbl[i-1]) > $signed(val)) begin
            tbl[i] = tbl[i-1]; i--;
          end
          tbl[i] = val;
          held++;
          a.pos = 4'(i);
        end
      end
      default: ;
    endcase
    a.cnt = held;
    return a;
  endfunction

  task automatic send_command(bate_pkg::op_t op, logic [4:0] idx, logic [31:0] val,
                              bit known, answer_t typed);
    answer_t a;
    while (!no_idle && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    a = predict_table(op, idx, val);
    answers_due.push_back(a);
    typed_due.push_back(typed);
    typed_valid.push_back(known);
    in_tvalid <= 1'b1;
    in_tdata <= {val, idx, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_limit(logic [4:0] lim);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= '0; cfg_pwdata <= 32'(lim);
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    cap_limit = lim;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return held ? tbl[$urandom_range(held - 1)] : 32'd0;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Result side: compare each transaction with the oldest expectation.
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.st = out_tdata[1:0];
      got.pos = out_tdata[5:2];
      got.rem = out_tdata[37:6];
      got.cnt = out_tdata[42:38];
      if (answers_due.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = answers_due.pop_front();
        if (typed_valid.pop_front() && typed_due[0] != want) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("table row %h disagrees with predictor %h",
                                         typed_due[0], want);
        end
        void'(typed_due.pop_front());
        if (got != want || out_tdata[47:43] != 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: st %0d/%0d pos %0d/%0d rem %h/%h cnt %0d/%0d",
                     want.st, got.st, want.pos, got.pos, want.rem, got.rem,
                     want.cnt, got.cnt);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cmd_row_t rows [$];
    cmd_row_t r;
    answer_t typed;
    failed = 0; mismatches = 0; watch = 0; hold_off = 0; no_idle = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    held = 0; cap_limit = 16;
    foreach (tbl[i]) tbl[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    rows = '{
      '{bate_pkg::OP_DELETE, 5'd0, 32'd0, 1, bate_pkg::ST_RANGE, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_INSERT, 5'd1, 32'd5, 1, bate_pkg::ST_RANGE, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_BSEARCH, 5'd0, 32'd5, 1, bate_pkg::ST_NOT_FOUND, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_TRANS, 5'd0, 32'd5, 1, bate_pkg::ST_NOT_FOUND, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_INSERT, 5'd0, 32'h8000_0000, 1, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd1},
      '{bate_pkg::OP_SORTED, 5'd31, 32'h7fff_ffff, 1, bate_pkg::ST_OK, 4'd1, 32'd0, 5'd2},
      '{bate_pkg::OP_SORTED, 5'd0, 32'd0, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_SORTED, 5'd0, 32'hffff_ffff, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_BSEARCH, 5'd0, 32'h7fff_ffff, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_BSEARCH, 5'd0, 32'd3, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_TRANS, 5'd0, 32'h8000_0000, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_TRANS, 5'd0, 32'h7fff_ffff, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_MTF, 5'd0, 32'd0, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_MTF, 5'd0, 32'd9, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_RSVD6, 5'd3, 32'd1, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_RSVD7, 5'd31, 32'hffff_ffff, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_DELETE, 5'd4, 32'd0, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_DELETE, 5'd0, 32'd0, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0},
      '{bate_pkg::OP_INSERT, 5'd2, 32'h5555_aaaa, 0, bate_pkg::ST_OK, 4'd0, 32'd0, 5'd0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      typed = '{r.st, r.pos, r.rem, r.cnt};
      send_command(r.op, r.idx, r.val, r.known, typed);
    end
    wait_drained();

    // Fill to the full capacity, prove both inserts refuse when full, then try two deletes.
    while (held < 16) send_command(bate_pkg::OP_INSERT, held, $urandom, 0, '0);
    send_command(bate_pkg::OP_INSERT, 5'd16, 32'd1, 1,
                 '{bate_pkg::ST_FULL, 4'd0, 32'd0, 5'd16});
    send_command(bate_pkg::OP_SORTED, 5'd0, 32'd1, 1,
                 '{bate_pkg::ST_FULL, 4'd0, 32'd0, 5'd16});
    send_command(bate_pkg::OP_DELETE, 5'd16, 32'd0, 1,
                 '{bate_pkg::ST_RANGE, 4'd0, 32'd0, 5'd16});
    send_command(bate_pkg::OP_DELETE, 5'd15, 32'd0, 0, '0);
    wait_drained();

    // The receiver holds off while items keep coming, so the input stalls.
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      repeat (6) send_command(bate_pkg::op_t'($urandom_range(7)), 5'($urandom_range(16)),
                              pick_value(), 0, '0);
    join
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_limit(5'd0);
        1: write_limit(5'd31);
        2: write_limit(5'd3);
        3: write_limit(5'd16);
        4: write_limit(5'($urandom_range(31)));
        default: write_limit(5'd8);
      endcase
      no_idle = (phase == 3);
      for (int j = 0; j < 170; j++) begin
        case ($urandom_range(9)) inside
          0, 1: send_command(bate_pkg::OP_INSERT, 5'($urandom_range(held + 1)),
                             pick_value(), 0, '0);
          2: send_command(bate_pkg::OP_SORTED, 5'($urandom_range(31)), pick_value(), 0, '0);
          3, 4: send_command(bate_pkg::OP_DELETE, 5'($urandom_range(held)), 32'd0, 0, '0);
          5: send_command(bate_pkg::OP_TRANS, 5'($urandom_range(31)), pick_value(), 0, '0);
          6: send_command(bate_pkg::OP_MTF, 5'($urandom_range(31)), pick_value(), 0, '0);
          7, 8: send_command(bate_pkg::OP_BSEARCH, 5'($urandom_range(31)), pick_value(),
                             0, '0);
          default: send_command(bate_pkg::op_t'($urandom_range(7)), 5'($urandom_range(31)),
                                $urandom, 0, '0);
        endcase
      end
      wait_drained();
    end

    if (failed || answers_due.size() != 0) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end
endmodule
